@@ hw/rtl/fcr_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcr_pkg: shared types and constants of the floppy controller registers
// Item codes, register offsets, status bits and the control/status bundles
// that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package fcr_pkg;

	localparam logic [2:0] MODE_RD    = 3'd0;
	localparam logic [2:0] MODE_WR    = 3'd1;
	localparam logic [2:0] MODE_TICK  = 3'd2;
	localparam logic [2:0] MODE_FILL  = 3'd3;
	localparam logic [2:0] MODE_DRAIN = 3'd4;

	localparam logic [3:0] REG_CMD  = 4'd0;
	localparam logic [3:0] REG_TRK  = 4'd1;
	localparam logic [3:0] REG_SEC  = 4'd2;
	localparam logic [3:0] REG_DATA = 4'd3;
	localparam logic [3:0] REG_ID   = 4'd15;

	localparam logic [7:0] ID_VALUE    = 8'h10;
	localparam logic [7:0] UNKNOWN_REG = 8'hFF;

	localparam logic [7:0] ST_NOTREADY = 8'h80;
	localparam logic [7:0] ST_ERROR    = 8'h10;
	localparam logic [7:0] ST_DRQ      = 8'h02;
	localparam logic [7:0] ST_BUSY     = 8'h01;

	localparam logic [1:0] DIR_NONE = 2'd0;
	localparam logic [1:0] DIR_IN   = 2'd1;
	localparam logic [1:0] DIR_OUT  = 2'd2;

	localparam logic [1:0] KIND_NONE  = 2'd0;
	localparam logic [1:0] KIND_LOAD  = 2'd1;
	localparam logic [1:0] KIND_STORE = 2'd2;
	localparam logic [1:0] KIND_BADSEC = 2'd3;

	localparam logic [1:0] CFG_PRESENT = 2'd0;
	localparam logic [1:0] CFG_SPT     = 2'd1;
	localparam logic [1:0] CFG_TRACKS  = 2'd2;
	localparam logic [1:0] CFG_SIZE    = 2'd3;

	typedef struct packed {
		logic latch;
		logic exec;
		logic loop_step;
		logic mul1;
		logic mul2;
		logic out_load;
	} fcr_cmd_t;

	typedef struct packed {
		logic need_loop;
		logic need_locate;
		logic loop_done;
	} fcr_stat_t;

endpackage

@@ hw/rtl/fcr_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcr_ctrl: sequencer of the floppy controller registers
// Walks one item through decode, execute, head stepping and offset math.
// ----------------------------------------------------------------------------
module fcr_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  fcr_pkg::fcr_stat_t stat,
	output fcr_pkg::fcr_cmd_t  cmd
);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_DECODE = 3'd1;
	localparam logic [2:0] S_EXEC   = 3'd2;
	localparam logic [2:0] S_LOOP   = 3'd3;
	localparam logic [2:0] S_MUL1   = 3'd4;
	localparam logic [2:0] S_MUL2   = 3'd5;
	localparam logic [2:0] S_FINISH = 3'd6;

	logic [2:0] state_q, state_d;
	logic       out_valid_q;
	logic       slot_free;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign slot_free = !out_valid_q || out_ready;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.latch = 1'b1;
					state_d   = S_DECODE;
				end
			end
			S_DECODE: state_d = S_EXEC;
			S_EXEC: begin
				cmd.exec = 1'b1;
				if (stat.need_loop) state_d = S_LOOP;
				else if (stat.need_locate) state_d = S_MUL1;
				else state_d = S_FINISH;
			end
			S_LOOP: begin
				cmd.loop_step = 1'b1;
				if (stat.loop_done) state_d = S_FINISH;
			end
			S_MUL1: begin
				cmd.mul1 = 1'b1;
				state_d  = S_MUL2;
			end
			S_MUL2: begin
				cmd.mul2 = 1'b1;
				state_d  = S_FINISH;
			end
			S_FINISH: begin
				if (slot_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	a_load_only_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> slot_free)
		else $error("result loaded over a pending beat");
	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("second item accepted while one is in work");
	a_loaded_is_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> out_valid_q)
		else $error("loaded result not presented");

endmodule

@@ hw/rtl/fcr_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcr_datapath: registers, sector buffer and offset arithmetic
// Holds the controller registers and executes the steps the sequencer asks for.
// ----------------------------------------------------------------------------
module fcr_datapath #(
	parameter int BUFFER_DEPTH = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	input  fcr_pkg::fcr_cmd_t  cmd,
	output fcr_pkg::fcr_stat_t stat,
	input  logic [2:0]         mode,
	input  logic [3:0]         reg_offset,
	input  logic [7:0]         write_data,
	input  logic [9:0]         buffer_index,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [10:0]        cfg_data,
	output logic [7:0]         read_data,
	output logic [1:0]         request_kind,
	output logic [24:0]        image_offset
);

	localparam int ADDR_W = $clog2(BUFFER_DEPTH);
	localparam int SZ_W   = $clog2(BUFFER_DEPTH + 1);

	typedef struct packed {
		logic [1:0] dir;
		logic [7:0] trk;
		logic [7:0] hd;
	} mv_t;

	// Item and configuration registers.
	logic [2:0]  mode_q;
	logic [3:0]  reg_q;
	logic [7:0]  wd_q;
	logic [9:0]  idx_q;
	logic        present_q;
	logic [6:0]  spt_q;
	logic [7:0]  tracks_q;
	logic [10:0] size_q;

	// Controller state.
	logic [7:0]      status_q, track_q, head_q, sector_q, buf0_q;
	logic [1:0]      dir_q;
	logic            last_t1_q, rd_act_q, wr_act_q;
	logic [SZ_W-1:0] bp_q;

	logic [7:0]      n_status, n_track, n_head, n_sector, n_buf0;
	logic [1:0]      n_dir;
	logic            n_last, n_rd_act, n_wr_act;
	logic [SZ_W-1:0] n_bp;
	logic [7:0]      n_rd;
	logic [1:0]      n_kind;

	logic [7:0]  rd_q;
	logic [1:0]  kind_q;
	logic [24:0] offset_q;
	logic [15:0] pos_s1;

	logic [7:0]        mem [BUFFER_DEPTH];
	logic [7:0]        mem_q;
	logic              zero_s1;
	logic [ADDR_W-1:0] rd_addr, mem_wa;
	logic              mem_we;

	logic [SZ_W-1:0] ss;
	logic [7:0]      limit;
	logic [7:0]      data_byte;
	logic            idx_ok, is_cmd, rd_cmd, wr_last;
	logic [3:0]      cls;
	mv_t             mv;

	function automatic mv_t move_head(input logic [1:0] d, input logic [1:0] cur,
		input logic [7:0] trk, input logic [7:0] hd, input logic [7:0] lim);
		mv_t r;
		r.dir = cur;
		r.trk = trk;
		r.hd  = hd;
		if (d == fcr_pkg::DIR_OUT) begin
			r.dir = d;
			if (trk != 8'd0) r.trk = trk - 8'd1;
			if (hd != 8'd0) r.hd = hd - 8'd1;
		end else if (d == fcr_pkg::DIR_IN) begin
			r.dir = d;
			if (trk != 8'hFF) r.trk = trk + 8'd1;
			if (hd < lim) r.hd = hd + 8'd1;
		end
		return r;
	endfunction

	always_comb begin
		if (size_q == 11'd0) ss = SZ_W'(1);
		else if (32'(size_q) > BUFFER_DEPTH) ss = SZ_W'(BUFFER_DEPTH);
		else ss = SZ_W'(size_q);
	end

	assign limit     = (tracks_q == 8'd0) ? 8'd0 : tracks_q - 8'd1;
	assign idx_ok    = 32'(idx_q) < BUFFER_DEPTH;
	assign cls       = wd_q[7:4];
	assign data_byte = zero_s1 ? buf0_q : mem_q;
	assign is_cmd    = (mode_q == fcr_pkg::MODE_WR) && (reg_q == fcr_pkg::REG_CMD) && present_q;
	assign rd_cmd    = is_cmd && ((cls == 4'h8) || (cls == 4'h9));
	assign wr_last   = (mode_q == fcr_pkg::MODE_WR) && (reg_q == fcr_pkg::REG_DATA)
		&& wr_act_q && (bp_q < ss) && ((bp_q + SZ_W'(1)) == ss);

	assign stat.need_loop   = is_cmd && (cls[3:1] == 3'd0);
	assign stat.need_locate = (rd_cmd || wr_last) && (sector_q != 8'd0);
	assign stat.loop_done   = cls[0] ? (track_q == buf0_q) : (head_q == 8'd0);

	always_comb begin
		if (mode_q == fcr_pkg::MODE_DRAIN) rd_addr = ADDR_W'(idx_q);
		else if (bp_q >= ss) rd_addr = ADDR_W'(ss - SZ_W'(1));
		else rd_addr = ADDR_W'(bp_q);
	end

	always_comb begin
		n_status = status_q;
		n_track  = track_q;
		n_head   = head_q;
		n_sector = sector_q;
		n_buf0   = buf0_q;
		n_dir    = dir_q;
		n_last   = last_t1_q;
		n_rd_act = rd_act_q;
		n_wr_act = wr_act_q;
		n_bp     = bp_q;
		n_rd     = 8'd0;
		n_kind   = fcr_pkg::KIND_NONE;
		mem_we   = 1'b0;
		mem_wa   = ADDR_W'(bp_q);
		mv       = move_head(fcr_pkg::DIR_NONE, dir_q, track_q, head_q, limit);
		if (cmd.exec) begin
			case (mode_q)
				fcr_pkg::MODE_RD: begin
					case (reg_q)
						fcr_pkg::REG_CMD: n_rd = status_q;
						fcr_pkg::REG_TRK: n_rd = track_q;
						fcr_pkg::REG_SEC: n_rd = sector_q;
						fcr_pkg::REG_DATA: begin
							if (!rd_act_q) n_rd = buf0_q;
							else begin
								n_rd = data_byte;
								if (bp_q < ss) begin
									if ((bp_q + SZ_W'(1)) == ss) begin
										n_status = status_q & ~(fcr_pkg::ST_BUSY | fcr_pkg::ST_DRQ);
										n_rd_act = 1'b0;
									end
									n_bp = bp_q + SZ_W'(1);
								end
							end
						end
						fcr_pkg::REG_ID: n_rd = fcr_pkg::ID_VALUE;
						default: n_rd = fcr_pkg::UNKNOWN_REG;
					endcase
				end
				fcr_pkg::MODE_WR: begin
					case (reg_q)
						fcr_pkg::REG_CMD: begin
							if (!present_q) n_status = fcr_pkg::ST_NOTREADY;
							else begin
								n_status = status_q & ~(fcr_pkg::ST_NOTREADY | fcr_pkg::ST_ERROR);
								n_last   = 1'b0;
								case (cls)
									4'h2, 4'h3, 4'h4, 4'h5, 4'h6, 4'h7: begin
										if (cls[3:1] == 3'd1)
											mv = move_head(dir_q, dir_q, track_q, head_q, limit);
										else if (cls[3:1] == 3'd2)
											mv = move_head(fcr_pkg::DIR_IN, dir_q, track_q, head_q, limit);
										else
											mv = move_head(fcr_pkg::DIR_OUT, dir_q, track_q, head_q, limit);
										n_dir    = mv.dir;
										n_track  = mv.trk;
										n_head   = mv.hd;
										n_status = n_status & ~(fcr_pkg::ST_BUSY | fcr_pkg::ST_DRQ);
										n_last   = 1'b1;
									end
									4'h8, 4'h9: begin
										if (sector_q == 8'd0) begin
											n_status = n_status | fcr_pkg::ST_ERROR;
											n_kind   = fcr_pkg::KIND_BADSEC;
										end else begin
											n_kind   = fcr_pkg::KIND_LOAD;
											n_rd_act = 1'b1;
											n_status = n_status | fcr_pkg::ST_BUSY | fcr_pkg::ST_DRQ;
											n_bp     = '0;
										end
									end
									4'hA, 4'hB: begin
										n_status = n_status | fcr_pkg::ST_BUSY | fcr_pkg::ST_DRQ;
										n_bp     = '0;
										n_wr_act = 1'b1;
									end
									4'hC, 4'hD: begin
										if ((status_q & fcr_pkg::ST_BUSY) != 8'd0)
											n_status = n_status & ~fcr_pkg::ST_BUSY;
										else begin
											n_status = n_status & ~(fcr_pkg::ST_BUSY | fcr_pkg::ST_DRQ);
											n_last   = 1'b1;
										end
									end
									default: ;
								endcase
							end
						end
						fcr_pkg::REG_TRK: n_track = wd_q;
						fcr_pkg::REG_SEC: n_sector = wd_q;
						fcr_pkg::REG_DATA: begin
							if (!wr_act_q) n_buf0 = wd_q;
							else if (bp_q < ss) begin
								if (bp_q == '0) n_buf0 = wd_q;
								else mem_we = 1'b1;
								n_bp = bp_q + SZ_W'(1);
								if (wr_last) begin
									n_status = status_q & ~(fcr_pkg::ST_BUSY | fcr_pkg::ST_DRQ);
									n_wr_act = 1'b0;
									if (sector_q == 8'd0) begin
										n_status = n_status | fcr_pkg::ST_ERROR;
										n_kind   = fcr_pkg::KIND_BADSEC;
									end else n_kind = fcr_pkg::KIND_STORE;
								end
							end
						end
						default: ;
					endcase
				end
				fcr_pkg::MODE_TICK: begin
					if (present_q && last_t1_q) n_status = status_q ^ fcr_pkg::ST_DRQ;
				end
				fcr_pkg::MODE_FILL: begin
					if (idx_ok) begin
						mem_wa = ADDR_W'(idx_q);
						if (idx_q == 10'd0) n_buf0 = wd_q;
						else mem_we = 1'b1;
					end
				end
				fcr_pkg::MODE_DRAIN: begin
					if (idx_ok) n_rd = data_byte;
				end
				default: ;
			endcase
		end
		if (cmd.loop_step) begin
			if (stat.loop_done) begin
				if (!cls[0]) n_track = 8'd0;
				n_status = status_q & ~(fcr_pkg::ST_BUSY | fcr_pkg::ST_DRQ);
				n_last   = 1'b1;
			end else begin
				if (!cls[0] || (track_q > buf0_q))
					mv = move_head(fcr_pkg::DIR_OUT, dir_q, track_q, head_q, limit);
				else
					mv = move_head(fcr_pkg::DIR_IN, dir_q, track_q, head_q, limit);
				n_dir   = mv.dir;
				n_track = mv.trk;
				n_head  = mv.hd;
			end
		end
		if (cmd.mul2) n_head = track_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			present_q <= 1'b0;
			spt_q     <= 7'd5;
			tracks_q  <= 8'd40;
			size_q    <= 11'd1024;
			status_q  <= '0;
			track_q   <= '0;
			head_q    <= '0;
			sector_q  <= '0;
			buf0_q    <= '0;
			dir_q     <= fcr_pkg::DIR_NONE;
			last_t1_q <= 1'b0;
			rd_act_q  <= 1'b0;
			wr_act_q  <= 1'b0;
			bp_q      <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					fcr_pkg::CFG_PRESENT: present_q <= cfg_data[0];
					fcr_pkg::CFG_SPT:     spt_q     <= cfg_data[6:0];
					fcr_pkg::CFG_TRACKS:  tracks_q  <= cfg_data[7:0];
					fcr_pkg::CFG_SIZE:    size_q    <= cfg_data;
					default: ;
				endcase
			end
			status_q  <= n_status;
			track_q   <= n_track;
			head_q    <= n_head;
			sector_q  <= n_sector;
			buf0_q    <= n_buf0;
			dir_q     <= n_dir;
			last_t1_q <= n_last;
			rd_act_q  <= n_rd_act;
			wr_act_q  <= n_wr_act;
			bp_q      <= n_bp;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_wa] <= wd_q;
		mem_q   <= mem[rd_addr];
		zero_s1 <= (rd_addr == '0);
		if (cmd.latch) begin
			mode_q <= mode;
			reg_q  <= reg_offset;
			wd_q   <= write_data;
			idx_q  <= buffer_index;
		end
		if (cmd.exec) begin
			rd_q     <= n_rd;
			kind_q   <= n_kind;
			offset_q <= '0;
		end
		if (cmd.mul1) pos_s1 <= 16'(head_q) * 16'(spt_q) + 16'(sector_q) - 16'd1;
		if (cmd.mul2) offset_q <= 25'(32'(pos_s1) * 32'(ss));
		if (cmd.out_load) begin
			read_data    <= rd_q;
			request_kind <= kind_q;
			image_offset <= offset_q;
		end
	end

endmodule

@@ hw/rtl/floppy_controller_registers.sv @@
`timescale 1ns / 1ps
// An accepted item passes decode and execute; its result is loaded in the finish state
// once the output slot is free. Restore and seek add head steps in the loop state, and
// sector offset math adds the two multiply states. One item is in work at a time; a new
// item is taken only after the last result is loaded.
// Reset (arst_n low) clears the controller state and buffer entry zero and sets the
// configuration to its defaults; other buffer entries and the item and result registers hold their last values.
// ----------------------------------------------------------------------------
// floppy_controller_registers: simplified floppy controller register file
// Command/status, track, sector and data registers with a sector buffer that
// the host fills and drains, and load/store sector requests on the result.
// ----------------------------------------------------------------------------
module floppy_controller_registers #(
	parameter int BUFFER_DEPTH = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  mode,
	input  logic [3:0]  reg_offset,
	input  logic [7:0]  write_data,
	input  logic [9:0]  buffer_index,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  read_data,
	output logic [1:0]  request_kind,
	output logic [24:0] image_offset,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [10:0] cfg_data
);

	// The sequencer and datapath talk only through these two bundles.
	fcr_pkg::fcr_cmd_t  cmd;
	fcr_pkg::fcr_stat_t stat;

	// Configuration beats are always taken; the user must send them only while idle, as the block does not enforce this.
	assign cfg_ready = 1'b1;

	fcr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	fcr_datapath #(
		.BUFFER_DEPTH(BUFFER_DEPTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.mode         (mode),
		.reg_offset   (reg_offset),
		.write_data   (write_data),
		.buffer_index (buffer_index),
		.cfg_we       (cfg_valid),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.read_data    (read_data),
		.request_kind (request_kind),
		.image_offset (image_offset)
	);

	// A result beat with no request never carries an offset.
	a_no_offset_without_request: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (request_kind == fcr_pkg::KIND_NONE ||
			request_kind == fcr_pkg::KIND_BADSEC)) |-> (image_offset == 25'd0))
		else $error("offset present without a sector request");
	// The sequencer never offers an input slot while a beat is still in work.
	a_single_item: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("input taken twice");
	// A result beat only appears after an item was accepted.
	a_no_spurious_beat: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(cmd.out_load))
		else $error("result beat without an item");

endmodule
